/* rtl/ct_pkg.sv */
// ----------------------------------------------------------------------------
// ct_pkg
// Shared types and constants for the columnar transposition block.
// ----------------------------------------------------------------------------
package ct_pkg;

	localparam int unsigned BLOCK_BYTES_DEF = 64;
	localparam int unsigned CNT_W           = 7;   // holds a byte count up to 64
	localparam int unsigned COL_W           = 5;
	localparam int unsigned MAX_COLS        = 16;
	localparam logic [COL_W-1:0] COLS_RESET = 5'd5;
	localparam logic [7:0]  PAD_BYTE        = 8'h20;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_MODE    = 1'b1;

	// One closed block waiting for the drain
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [COL_W-1:0] cols;
		logic             mode;
		logic             ovf;
	} job_t;

endpackage

/* rtl/ct_front.sv */
// ----------------------------------------------------------------------------
// ct_front
// Byte intake: capacity check, block store and job hand-off on the last byte.
// ----------------------------------------------------------------------------
module ct_front #(
	parameter int unsigned BLOCK_BYTES = ct_pkg::BLOCK_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     data_byte,
	input  logic                           last_in,
	input  logic [ct_pkg::COL_W-1:0]       columns,
	input  logic                           mode,
	output logic                           push,
	output ct_pkg::job_t                   job,
	input  logic [$clog2(BLOCK_BYTES)-1:0] rd_addr,
	output logic [7:0]                     rd_data
);

	localparam int unsigned CW = ct_pkg::CNT_W;
	localparam int unsigned AW = $clog2(BLOCK_BYTES);

	logic [7:0]          mem [BLOCK_BYTES];
	logic [CW-1:0]       cnt_q;
	logic                drop_q;
	logic [CW-1:0]       cap_tbl [16];
	logic [ct_pkg::COL_W-1:0] cols_eff;
	logic [3:0]          cm1;
	logic [CW-1:0]       cap;
	logic [CW-1:0]       lim;
	logic                fits;
	logic [CW-1:0]       n_next;
	logic                enc_over;

	// largest multiple of the column count that fits the store
	for (genvar Col = 1; Col <= 16; Col++) begin : g_cap
		localparam int unsigned CapC = (BLOCK_BYTES / Col) * Col;
		assign cap_tbl[Col-1] = CW'(CapC);
	end

	always_comb begin
		if (columns == '0) begin
			cols_eff = ct_pkg::COL_W'(1);
		end else if (columns > ct_pkg::COL_W'(ct_pkg::MAX_COLS)) begin
			cols_eff = ct_pkg::COL_W'(ct_pkg::MAX_COLS);
		end else begin
			cols_eff = columns;
		end
		cm1      = 4'(cols_eff - ct_pkg::COL_W'(1));
		cap      = cap_tbl[cm1];
		lim      = (mode == ct_pkg::MODE_DEC) ? CW'(BLOCK_BYTES) : cap;
		fits     = cnt_q < lim;
		n_next   = fits ? cnt_q + CW'(1) : cnt_q;
		// columns may have shrunk the padded capacity mid-block
		enc_over = (mode == ct_pkg::MODE_ENC) && (n_next > cap);
		job.n    = enc_over ? cap : n_next;
		job.cols = cols_eff;
		job.mode = mode;
		job.ovf  = drop_q | ~fits | enc_over;
	end

	assign push = accept & last_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (last_in) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				cnt_q  <= n_next;
				drop_q <= drop_q | ~fits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fits) begin
			mem[cnt_q[AW-1:0]] <= data_byte;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/ct_queue.sv */
// ----------------------------------------------------------------------------
// ct_queue
// Two-entry job queue between intake and drain.
// ----------------------------------------------------------------------------
module ct_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  ct_pkg::job_t job_in,
	input  logic         pop,
	output logic         valid,
	output ct_pkg::job_t job_out
);

	ct_pkg::job_t ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign valid   = count_q != 2'd0;
	assign job_out = ent_q[rd_ptr_q];
	assign do_push = push && (count_q != 2'd2);
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= job_in;
	end

endmodule

/* rtl/ct_back.sv */
// ----------------------------------------------------------------------------
// ct_back
// Drain sequencer: row count by restoring division, then strided store reads.
// ----------------------------------------------------------------------------
module ct_back #(
	parameter int unsigned BLOCK_BYTES = ct_pkg::BLOCK_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	input  ct_pkg::job_t                   job,
	output logic                           pop,
	output logic                           active,
	output logic [$clog2(BLOCK_BYTES)-1:0] rd_addr,
	input  logic [7:0]                     rd_data,
	output logic                           result_valid,
	output logic [7:0]                     out_byte,
	output logic                           last_out,
	output logic                           overflow
);

	localparam int unsigned CW = ct_pkg::CNT_W;
	localparam int unsigned AW = $clog2(BLOCK_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_PREP  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            n_q;
	logic [ct_pkg::COL_W-1:0] c_q;
	logic                     mode_q;
	logic                     ovf_q;
	logic [CW-1:0]            dvd_q;
	logic [CW-1:0]            quo_q;
	logic [3:0]               rem_q;
	logic [2:0]               step_q;
	logic [CW-1:0]            stride_q;
	logic [CW-1:0]            in_last_q;
	logic [CW-1:0]            out_last_q;
	logic [CW-1:0]            in_q;
	logic [CW-1:0]            out_q;
	logic [CW-1:0]            idx_q;
	logic                     valid_s1;
	logic                     pad_s1;
	logic                     last_s1;
	logic                     ovf_s1;

	logic [4:0]               trial;
	logic                     ge;
	logic [CW-1:0]            rows;
	logic                     in_wrap;
	logic                     drain_last;

	always_comb begin
		trial      = {rem_q, dvd_q[CW-1]};
		ge         = trial >= c_q;
		rows       = (mode_q == ct_pkg::MODE_DEC) ? quo_q : quo_q + CW'(rem_q != 4'd0);
		in_wrap    = in_q == in_last_q;
		drain_last = in_wrap && (out_q == out_last_q);
	end

	assign active  = state_q != ST_IDLE;
	assign pop     = (state_q == ST_IDLE) && job_valid;
	assign rd_addr = idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_DRAIN);
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 3'(CW - 1)) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= (rows == '0) ? ST_IDLE : ST_DRAIN;
				end
				ST_DRAIN: begin
					if (drain_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pad_s1  <= idx_q >= n_q;
		last_s1 <= drain_last;
		ovf_s1  <= ovf_q;
		unique case (state_q)
			ST_IDLE: begin
				n_q    <= job.n;
				c_q    <= job.cols;
				mode_q <= job.mode;
				ovf_q  <= job.ovf;
				dvd_q  <= job.n;
				quo_q  <= '0;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= ge ? 4'(trial - c_q) : trial[3:0];
				quo_q  <= {quo_q[CW-2:0], ge};
				dvd_q  <= {dvd_q[CW-2:0], 1'b0};
				step_q <= step_q + 3'd1;
			end
			ST_PREP: begin
				// encrypt walks a column (stride columns), decrypt a row (stride rows)
				if (mode_q == ct_pkg::MODE_DEC) begin
					stride_q   <= rows;
					in_last_q  <= CW'(c_q) - CW'(1);
					out_last_q <= rows - CW'(1);
				end else begin
					stride_q   <= CW'(c_q);
					in_last_q  <= rows - CW'(1);
					out_last_q <= CW'(c_q) - CW'(1);
				end
				in_q  <= '0;
				out_q <= '0;
				idx_q <= '0;
			end
			ST_DRAIN: begin
				if (in_wrap) begin
					in_q  <= '0;
					out_q <= out_q + CW'(1);
					idx_q <= out_q + CW'(1);
				end else begin
					in_q  <= in_q + CW'(1);
					idx_q <= idx_q + stride_q;
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	assign result_valid = valid_s1;
	assign out_byte     = pad_s1 ? ct_pkg::PAD_BYTE : rd_data;
	assign last_out     = last_s1;
	assign overflow     = ovf_s1;

	a_strobe_follows_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_DRAIN))
		else $error("result strobe without a drain read");

	a_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (idx_q < CW'(BLOCK_BYTES)))
		else $error("drain address beyond block store");

	a_dec_no_pad: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && (mode_q == ct_pkg::MODE_DEC)) |-> (idx_q < n_q))
		else $error("decrypt drain read a pad position");

endmodule

/* rtl/columnar_transposition_block.sv */
// ----------------------------------------------------------------------------
// columnar_transposition_block
// Columnar transposition of byte blocks with APB configuration.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle (start high, busy low) until a byte with
// last_in closes the block. From the cycle after the closing byte busy stays
// high: first the row count is formed (a hand-off step, a seven-step
// restoring divider over the byte count and a set-up step), then the block
// drains at one byte per cycle, rows*columns bytes, limited by the single
// read port of the block store.
// Each byte appears for one cycle with result_valid and cannot be held off;
// it shows in the cycle after its store read. A block that yields no rows closes
// without results. Registers: columns at 0x0, mode at 0x4.
module columnar_transposition_block #(
	parameter int unsigned BLOCK_BYTES = ct_pkg::BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  data_byte,
	input  logic        last_in,
	output logic        result_valid,
	output logic [7:0]  out_byte,
	output logic        last_out,
	output logic        overflow
);

	localparam int unsigned AW = $clog2(BLOCK_BYTES);

	logic [ct_pkg::COL_W-1:0] columns_q;
	logic                     mode_q;
	logic                     cfg_wr;
	logic                     accept;
	logic                     push;
	logic                     pop;
	logic                     job_valid;
	logic                     back_active;
	ct_pkg::job_t             job_in;
	ct_pkg::job_t             job_out;
	logic [AW-1:0]            rd_addr;
	logic [7:0]               rd_data;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= ct_pkg::COLS_RESET;
			mode_q    <= ct_pkg::MODE_ENC;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ct_pkg::REG_COLUMNS: columns_q <= pwdata[ct_pkg::COL_W-1:0];
				ct_pkg::REG_MODE:    mode_q    <= pwdata[0];
				default:             mode_q    <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ct_pkg::REG_COLUMNS: prdata = 32'(columns_q);
			ct_pkg::REG_MODE:    prdata = 32'(mode_q);
			default:             prdata = '0;
		endcase
	end

	// the store is shared, so intake waits until the drain has read it out
	assign busy   = job_valid | back_active;
	assign accept = start & ~busy;

	ct_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_in   (last_in),
		.columns   (columns_q),
		.mode      (mode_q),
		.push      (push),
		.job       (job_in),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	ct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.valid   (job_valid),
		.job_out (job_out)
	);

	ct_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job_out),
		.pop          (pop),
		.active       (back_active),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.last_out     (last_out),
		.overflow     (overflow)
	);

endmodule
